FILE: design/seq_pkg.sv
package seq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 16;
    localparam int PERSON_W    = 8;
    localparam int UNITS_W     = 12;
    localparam int KIND_W      = 2;

    localparam logic [TIME_W-1:0] LIMIT_RESET = 16'd1000;
    localparam logic [TIME_W-1:0] TIME_MAX    = 16'hFFFF;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_POP = 1'b1;

    localparam logic EV_ARRIVE = 1'b0;
    localparam logic EV_DEPART = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ADD_OK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TERM   = 2'd3;

    typedef struct packed {
        logic              ins_arrive;
        logic              ins_depart;
        logic              drop_head;
        logic              set_stop;
        logic              set_clock;
        logic              load_out;
        logic [KIND_W-1:0] out_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic stopped;
        logic past_limit;
    } dp_status_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [UNITS_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {{(TIME_W + 1 - UNITS_W){1'b0}}, b};
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

endpackage

FILE: design/seq_ctrl.sv
module seq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_op,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  seq_pkg::dp_status_t status,
    output seq_pkg::dp_cmd_t    cmd
);
    import seq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_INS2 = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic accept;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == OP_ADD) begin
                        if (status.full) begin
                            cmd.load_out = 1'b1;
                            cmd.out_kind = KIND_FULL;
                        end else begin
                            cmd.ins_arrive = 1'b1;
                            state_next     = ST_INS2;
                        end
                    end else if (status.stopped || status.empty) begin
                        cmd.set_stop = 1'b1;
                        cmd.load_out = 1'b1;
                        cmd.out_kind = KIND_TERM;
                    end else if (status.past_limit) begin
                        // head is discarded, clock stays
                        cmd.drop_head = 1'b1;
                        cmd.set_stop  = 1'b1;
                        cmd.load_out  = 1'b1;
                        cmd.out_kind  = KIND_TERM;
                    end else begin
                        cmd.drop_head = 1'b1;
                        cmd.set_clock = 1'b1;
                        cmd.load_out  = 1'b1;
                        cmd.out_kind  = KIND_POP;
                    end
                end
            end
            ST_INS2: begin
                cmd.ins_depart = 1'b1;
                cmd.load_out   = 1'b1;
                cmd.out_kind   = KIND_ADD_OK;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: design/seq_datapath.sv
module seq_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [seq_pkg::TIME_W-1:0]    cfg_wr_data,
    input  logic [seq_pkg::PERSON_W-1:0]  s_person_id,
    input  logic [seq_pkg::UNITS_W-1:0]   s_stay_units,
    input  logic [seq_pkg::UNITS_W-1:0]   s_next_gap,
    input  seq_pkg::dp_cmd_t              cmd,
    output seq_pkg::dp_status_t           status,
    output logic [seq_pkg::KIND_W-1:0]    m_kind,
    output logic [seq_pkg::TIME_W-1:0]    m_event_time,
    output logic [seq_pkg::PERSON_W-1:0]  m_event_person,
    output logic                          m_event_type
);
    import seq_pkg::*;

    // sorted shift-register queue, head at cell 0
    logic [TIME_W-1:0]   slot_time_reg   [QUEUE_DEPTH];
    logic [PERSON_W-1:0] slot_person_reg [QUEUE_DEPTH];
    logic                slot_type_reg   [QUEUE_DEPTH];
    logic [TIME_W-1:0]   slot_time_next   [QUEUE_DEPTH];
    logic [PERSON_W-1:0] slot_person_next [QUEUE_DEPTH];
    logic                slot_type_next   [QUEUE_DEPTH];

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TIME_W-1:0]   arrival_reg, arrival_next;
    logic [TIME_W-1:0]   clock_reg, clock_next;
    logic                stopped_reg, stopped_next;
    logic [TIME_W-1:0]   limit_reg, limit_next;
    logic [TIME_W-1:0]   depart_time_reg;
    logic [PERSON_W-1:0] depart_person_reg;

    logic [KIND_W-1:0]   kind_reg;
    logic [TIME_W-1:0]   out_time_reg;
    logic [PERSON_W-1:0] out_person_reg;
    logic                out_type_reg;

    logic                ins_en;
    logic [TIME_W-1:0]   ins_time;
    logic [PERSON_W-1:0] ins_person;
    logic                ins_type;
    logic [QUEUE_DEPTH-1:0] ge;

    assign ins_en     = cmd.ins_arrive || cmd.ins_depart;
    assign ins_time   = cmd.ins_depart ? depart_time_reg : arrival_reg;
    assign ins_person = cmd.ins_depart ? depart_person_reg : s_person_id;
    assign ins_type   = cmd.ins_depart ? EV_DEPART : EV_ARRIVE;

    assign status.full       = ({1'b0, count_reg} + (CNT_W + 1)'(2))
                               > (CNT_W + 1)'(QUEUE_DEPTH);
    assign status.empty      = (count_reg == '0);
    assign status.stopped    = stopped_reg;
    assign status.past_limit = clock_reg > limit_reg;

    // ge marks cells at or after the insert point; monotonic since the queue is sorted
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            ge[k] = (CNT_W'(k) >= count_reg) || (slot_time_reg[k] >= ins_time);
        end
    end

    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            slot_time_next[k]   = slot_time_reg[k];
            slot_person_next[k] = slot_person_reg[k];
            slot_type_next[k]   = slot_type_reg[k];
            if (ins_en) begin
                if (ge[k] && (k == 0 || !ge[(k == 0) ? 0 : k - 1])) begin
                    slot_time_next[k]   = ins_time;
                    slot_person_next[k] = ins_person;
                    slot_type_next[k]   = ins_type;
                end else if (ge[k] && k > 0) begin
                    slot_time_next[k]   = slot_time_reg[(k == 0) ? 0 : k - 1];
                    slot_person_next[k] = slot_person_reg[(k == 0) ? 0 : k - 1];
                    slot_type_next[k]   = slot_type_reg[(k == 0) ? 0 : k - 1];
                end
            end else if (cmd.drop_head && k + 1 < QUEUE_DEPTH) begin
                slot_time_next[k]   = slot_time_reg[(k + 1 < QUEUE_DEPTH) ? k + 1 : k];
                slot_person_next[k] = slot_person_reg[(k + 1 < QUEUE_DEPTH) ? k + 1 : k];
                slot_type_next[k]   = slot_type_reg[(k + 1 < QUEUE_DEPTH) ? k + 1 : k];
            end
        end
    end

    always_comb begin
        count_next   = count_reg;
        arrival_next = arrival_reg;
        clock_next   = clock_reg;
        stopped_next = stopped_reg;
        limit_next   = limit_reg;
        if (ins_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.drop_head) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.ins_arrive) begin
            arrival_next = sat_add(arrival_reg, s_next_gap);
        end
        if (cmd.set_clock) begin
            clock_next = slot_time_reg[0];
        end
        if (cmd.set_stop) begin
            stopped_next = 1'b1;
        end
        if (cfg_wr_en) begin
            limit_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            arrival_reg <= '0;
            clock_reg   <= '0;
            stopped_reg <= 1'b0;
            limit_reg   <= LIMIT_RESET;
        end else begin
            count_reg   <= count_next;
            arrival_reg <= arrival_next;
            clock_reg   <= clock_next;
            stopped_reg <= stopped_next;
            limit_reg   <= limit_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            slot_time_reg[k]   <= slot_time_next[k];
            slot_person_reg[k] <= slot_person_next[k];
            slot_type_reg[k]   <= slot_type_next[k];
        end
        if (cmd.ins_arrive) begin
            depart_time_reg   <= sat_add(arrival_reg, s_stay_units);
            depart_person_reg <= s_person_id;
        end
        if (cmd.load_out) begin
            kind_reg <= cmd.out_kind;
            if (cmd.out_kind == KIND_POP) begin
                out_time_reg   <= slot_time_reg[0];
                out_person_reg <= slot_person_reg[0];
                out_type_reg   <= slot_type_reg[0];
            end else if (cmd.out_kind == KIND_TERM) begin
                out_time_reg   <= clock_reg;
                out_person_reg <= '0;
                out_type_reg   <= 1'b0;
            end else begin
                out_time_reg   <= '0;
                out_person_reg <= '0;
                out_type_reg   <= 1'b0;
            end
        end
    end

    assign m_kind         = kind_reg;
    assign m_event_time   = out_time_reg;
    assign m_event_person = out_person_reg;
    assign m_event_type   = out_type_reg;

endmodule

FILE: design/sorted_event_queue.sv
// Results: a pop or a refused add registers its result on the input beat, shown in the cycle after;
// an accepted add does one sorted insert in ST_IDLE and one in ST_INS2, which registers its result.
// Throughput: one pop per cycle while the sink holds m_ready high; no new beat is taken during
// an add's second insert. The shift-register queue takes one insert or one removal per cycle.
// Reset (aresetn low, synchronous): queue empty, clocks zero, not stopped, limit 1000.
module sorted_event_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [seq_pkg::TIME_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [seq_pkg::PERSON_W-1:0]  s_person_id,
    input  logic [seq_pkg::UNITS_W-1:0]   s_stay_units,
    input  logic [seq_pkg::UNITS_W-1:0]   s_next_gap,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [seq_pkg::KIND_W-1:0]    m_kind,
    output logic [seq_pkg::TIME_W-1:0]    m_event_time,
    output logic [seq_pkg::PERSON_W-1:0]  m_event_person,
    output logic                          m_event_type
);
    import seq_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    seq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    seq_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_person_id    (s_person_id),
        .s_stay_units   (s_stay_units),
        .s_next_gap     (s_next_gap),
        .cmd            (cmd),
        .status         (status),
        .m_kind         (m_kind),
        .m_event_time   (m_event_time),
        .m_event_person (m_event_person),
        .m_event_type   (m_event_type)
    );

endmodule

FILE: tb/sorted_event_queue_tb.sv
`timescale 1ns / 1ps
module sorted_event_queue_tb;
    import seq_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 150;
    localparam int MAX_PRINTS  = 100;

    typedef struct packed {
        logic                op;
        logic [PERSON_W-1:0] person;
        logic [UNITS_W-1:0]  stay;
        logic [UNITS_W-1:0]  gap;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [TIME_W-1:0]   at;
        logic [PERSON_W-1:0] person;
        logic                ev;
    } evt_t;

    logic                aclk         = 1'b0;
    logic                aresetn      = 1'b0;
    logic                cfg_wr_en    = 1'b0;
    logic [TIME_W-1:0]   cfg_wr_data  = '0;
    logic                s_valid      = 1'b0;
    logic                s_op         = 1'b0;
    logic [PERSON_W-1:0] s_person_id  = '0;
    logic [UNITS_W-1:0]  s_stay_units = '0;
    logic [UNITS_W-1:0]  s_next_gap   = '0;
    logic                m_ready      = 1'b0;
    logic                s_ready;
    logic                m_valid;
    logic [KIND_W-1:0]   m_kind;
    logic [TIME_W-1:0]   m_event_time;
    logic [PERSON_W-1:0] m_event_person;
    logic                m_event_type;

    sorted_event_queue dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_person_id   (s_person_id),
        .s_stay_units  (s_stay_units),
        .s_next_gap    (s_next_gap),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_event_time  (m_event_time),
        .m_event_person(m_event_person),
        .m_event_type  (m_event_type)
    );

    always #10 aclk = ~aclk;

    // scheduler state mirrored on the testbench side
    logic [TIME_W-1:0]   q_time   [QUEUE_DEPTH];
    logic [PERSON_W-1:0] q_person [QUEUE_DEPTH];
    logic                q_type   [QUEUE_DEPTH];
    int                  q_count      = 0;
    logic [TIME_W-1:0]   next_arrival = '0;
    logic [TIME_W-1:0]   sim_now      = '0;
    logic [TIME_W-1:0]   time_limit   = LIMIT_RESET;
    logic                halted       = 1'b0;

    req_t req_backlog [$];
    evt_t due_events  [$];

    int   err_cnt   = 0;
    int   res_seen  = 0;
    int   beats_in  = 0;
    int   cycles    = 0;
    logic tail      = 1'b0;

    int   src_gap   = 0;
    int   src_quiet = 0;
    int   sink_gap  = 0;
    int   sink_quiet = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    function automatic logic [TIME_W-1:0] sum_clip(input logic [TIME_W-1:0] a,
                                                   input logic [UNITS_W-1:0] b);
        int s;
        s = int'(a) + int'(b);
        return (s > int'(TIME_MAX)) ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    // new entry lands ahead of any entry with the same time
    task automatic slot_insert(input logic [TIME_W-1:0] t, input logic [PERSON_W-1:0] who,
                               input logic typ);
        int pos;
        pos = 0;
        while (pos < q_count && q_time[pos] < t)
            pos++;
        for (int k = q_count; k > pos; k--) begin
            q_time[k]   = q_time[k-1];
            q_person[k] = q_person[k-1];
            q_type[k]   = q_type[k-1];
        end
        q_time[pos]   = t;
        q_person[pos] = who;
        q_type[pos]   = typ;
        q_count++;
    endtask

    task automatic slot_drop();
        for (int k = 0; k + 1 < q_count; k++) begin
            q_time[k]   = q_time[k+1];
            q_person[k] = q_person[k+1];
            q_type[k]   = q_type[k+1];
        end
        q_count--;
    endtask

    task automatic queue_step(input req_t b, output evt_t r);
        r = '0;
        if (b.op == OP_ADD) begin
            if (q_count + 2 > QUEUE_DEPTH) begin
                r.kind = KIND_FULL;
            end else begin
                slot_insert(next_arrival, b.person, EV_ARRIVE);
                slot_insert(sum_clip(next_arrival, b.stay), b.person, EV_DEPART);
                next_arrival = sum_clip(next_arrival, b.gap);
                r.kind = KIND_ADD_OK;
            end
        end else if (halted || q_count == 0) begin
            halted = 1'b1;
            r.kind = KIND_TERM;
            r.at   = sim_now;
        end else if (sim_now > time_limit) begin
            // head is thrown away, clock stays where it was
            slot_drop();
            halted = 1'b1;
            r.kind = KIND_TERM;
            r.at   = sim_now;
        end else begin
            sim_now  = q_time[0];
            r.kind   = KIND_POP;
            r.at     = q_time[0];
            r.person = q_person[0];
            r.ev     = q_type[0];
            slot_drop();
        end
    endtask

    task automatic send(input logic op, input logic [PERSON_W-1:0] p,
                        input logic [UNITS_W-1:0] s, input logic [UNITS_W-1:0] g);
        req_t b;
        evt_t r;
        b = {op, p, s, g};
        queue_step(b, r);
        req_backlog.push_back(b);
        due_events.push_back(r);
    endtask

    task automatic send_pop_any();
        send(OP_POP, PERSON_W'($urandom), UNITS_W'($urandom), UNITS_W'($urandom));
    endtask

    function automatic logic [UNITS_W-1:0] rand_units(input int wide_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < wide_pct)
            return UNITS_W'($urandom_range(0, 4095));
        if (r < wide_pct + 23)
            return UNITS_W'($urandom_range(0, 127));
        return UNITS_W'($urandom_range(0, 7));
    endfunction

    // pops only while they cannot stop the run; add share drifts so the queue
    // fills to full and drains back
    task automatic run_random(input int n, input int wide_pct);
        int add_pct;
        add_pct = 50;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: add_pct = 25;
                    1: add_pct = 55;
                    default: add_pct = 85;
                endcase
            end
            if ($urandom_range(0, 99) >= add_pct && q_count > 0 && sim_now <= time_limit)
                send_pop_any();
            else
                send(OP_ADD, PERSON_W'($urandom), rand_units(wide_pct), rand_units(wide_pct));
        end
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || s_valid || due_events.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [TIME_W-1:0] v);
        wait_drained();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        time_limit = v;
    endtask

    task automatic report_error(input string msg);
        if (err_cnt < MAX_PRINTS)
            $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                               input logic [TIME_W-1:0] want);
        if (got !== want)
            report_error($sformatf("beat %0d %s got %h want %h", res_seen, name, got, want));
    endtask

    initial begin
        logic past_limit_stop;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // equal times, field extremes; the last pop moves the clock past the reset limit
        send(OP_ADD, 8'h00, 12'd0, 12'd0);
        send(OP_ADD, 8'hFF, 12'hFFF, 12'd0);
        send(OP_ADD, 8'h5A, 12'd1, 12'hFFF);
        send(OP_ADD, 8'hA5, 12'd0, 12'd1);
        repeat (6) send(OP_POP, 8'hFF, 12'hFFF, 12'hFFF);
        send(OP_ADD, 8'h3C, 12'hA5A, 12'h5A5);
        send(OP_ADD, 8'hC3, 12'h5A5, 12'hA5A);

        set_limit(TIME_MAX);
        run_random(1000, 2);
        set_limit(sum_clip(sim_now, UNITS_W'($urandom_range(0, 3000))));
        run_random(250, 2);
        set_limit(TIME_MAX);
        run_random(350, 50);   // wide gaps drive the arrival time into saturation

        wait_drained();
        tail = 1'b1;
        past_limit_stop = (sim_now != '0) && ($urandom_range(0, 1) == 1);
        if (!past_limit_stop) begin
            while (q_count > 0)
                send_pop_any();
        end
        set_limit('0);
        send_pop_any();
        send_pop_any();
        send(OP_ADD, PERSON_W'($urandom), UNITS_W'($urandom), UNITS_W'($urandom));
        send_pop_any();
        repeat (20) send(1'($urandom), PERSON_W'($urandom), UNITS_W'($urandom),
                         UNITS_W'($urandom));

        wait_drained();
        repeat (20) @(posedge aclk);
        if (err_cnt == 0)
            $display("sorted_event_queue_tb: done, clean");
        else
            $display("sorted_event_queue_tb: done, errors");
        $finish;
    end

    // input driver
    always @(posedge aclk) begin
        req_t cur;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                beats_in <= beats_in + 1;
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
                cur = req_backlog.pop_front();
                s_op         <= cur.op;
                s_person_id  <= cur.person;
                s_stay_units <= cur.stay;
                s_next_gap   <= cur.gap;
                s_valid      <= 1'b1;
                if (!tail) begin
                    if (src_quiet > 0)
                        src_quiet--;
                    else if ($urandom_range(0, 39) == 0)
                        src_quiet = $urandom_range(20, 120);
                    else if ($urandom_range(0, 4) == 0)
                        src_gap = $urandom_range(1, 13);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result sink: random stalls plus one long hold-off that backs up the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && beats_in >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!tail) begin
                if (sink_quiet > 0)
                    sink_quiet--;
                else if ($urandom_range(0, 39) == 0)
                    sink_quiet = $urandom_range(20, 120);
                else if ($urandom_range(0, 4) == 0)
                    sink_gap = $urandom_range(1, 13);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        evt_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_events.size() == 0) begin
                report_error($sformatf("beat %0d unexpected, kind %h", res_seen, m_kind));
            end else begin
                want = due_events.pop_front();
                check_field("kind", TIME_W'(m_kind), TIME_W'(want.kind));
                check_field("event_time", m_event_time, want.at);
                check_field("event_person", TIME_W'(m_event_person), TIME_W'(want.person));
                check_field("event_type", TIME_W'(m_event_type), TIME_W'(want.ev));
            end
            res_seen++;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sorted_event_queue_tb: done, errors");
            $finish;
        end
    end

endmodule

FILE: filelist.f
design/seq_pkg.sv
design/seq_ctrl.sv
design/seq_datapath.sv
design/sorted_event_queue.sv
tb/sorted_event_queue_tb.sv
